// ===== sv/wsd_pkg.sv =====
// package for the work-stealing deque set: sequencer states and command/status codes
// no dependencies; imported by work_stealing_deque_set_core
package wsd_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_READ
  } state_e;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_STEAL = 2'd2
  } cmd_e;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;
  localparam logic [1:0] STATUS_RANGE = 2'd3;

  localparam logic [2:0] ACTIVE_WORKERS_RESET = 3'd4;

endpackage

// ===== sv/wsd_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module wsd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/work_stealing_deque_set_core.sv =====
// work-stealing deque set: one bounded ring deque per worker in a shared slot ram
// depends on wsd_pkg and wsd_ram
//
// usage:
//   input channel (in_valid_i/in_ready_o) carries cmd_i, worker_i, work_item_i;
//   output channel (out_valid_o/out_ready_i) returns status_o, taken_item_o,
//   source_worker_o, one result per input transaction.
//   config channel (cfg_valid_i/cfg_ready_o) writes the active worker count,
//   always ready; write it only while the block is idle.
// transaction flow:
//   one transaction at a time; in_ready_o is high only in the idle state.
//   push, range error, empty pop and unused cmd: finished in the decode state.
//   pop: decode, then the read state (one slot ram read with registered data).
//   steal: decode, then a scan of up to active count - 1 victims that tests one
//   deque per cycle while the result register is free, plus a ram read on a hit.
//   a new transaction can be accepted the cycle after the result is produced.
// reset: pointers clear, all deques empty, active count 4; slot ram not cleared.
// stall: with the result register still full, the sequencer holds before it
//   changes any state, so no transaction is lost or repeated.
module work_stealing_deque_set_core
  import wsd_pkg::*;
#(
  parameter int NUM_WORKERS = 4,
  parameter int DEQUE_DEPTH = 256,
  parameter int ITEM_WIDTH  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            cmd_i,
  input  logic [1:0]            worker_i,
  input  logic [ITEM_WIDTH-1:0] work_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            status_o,
  output logic [ITEM_WIDTH-1:0] taken_item_o,
  output logic [1:0]            source_worker_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [2:0]            cfg_active_workers_i
);

  localparam int SW = $clog2(DEQUE_DEPTH);
  localparam int PW = SW + 1;
  localparam int WW = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
  localparam int IXW = (WW > 3) ? WW : 3;
  localparam int RAM_DEPTH = NUM_WORKERS * DEQUE_DEPTH;
  localparam int AW = $clog2(RAM_DEPTH);
  localparam logic [2:0] NW_CLAMP = (NUM_WORKERS > 7) ? 3'd7 : 3'(NUM_WORKERS);
  localparam logic [PW-1:0] FULL_FILL = PW'(DEQUE_DEPTH - 1);

  state_e state_q, state_d;
  logic [1:0]            cmd_q;
  logic [1:0]            w_q;
  logic [ITEM_WIDTH-1:0] item_q;
  logic [2:0]            v_q, v_d;
  logic [2:0]            tries_q, tries_d;
  logic [2:0]            cfg_q;
  logic [PW-1:0]         top_q [NUM_WORKERS];
  logic [PW-1:0]         top_d [NUM_WORKERS];
  logic [PW-1:0]         bot_q [NUM_WORKERS];
  logic [PW-1:0]         bot_d [NUM_WORKERS];

  logic                  out_valid_q;
  logic [1:0]            status_q;
  logic [ITEM_WIDTH-1:0] taken_q;
  logic [1:0]            src_q;

  logic                  fin;
  logic [1:0]            fin_status;
  logic [ITEM_WIDTH-1:0] fin_item;
  logic [1:0]            fin_src;

  logic                  out_free;
  logic [2:0]            live;
  logic                  w_bad;
  logic [IXW-1:0]        sel_ext;
  logic [WW-1:0]         sel_idx;
  logic [PW-1:0]         sel_top, sel_bot, fill, nb;
  logic                  empty, full, hit;
  logic [2:0]            next_of_w, next_of_v;

  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [ITEM_WIDTH-1:0] ram_rdata;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    if (cfg_q == 3'd0) begin
      live = 3'd1;
    end else if (cfg_q > NW_CLAMP) begin
      live = NW_CLAMP;
    end else begin
      live = cfg_q;
    end
  end

  assign w_bad = {1'b0, w_q} >= live;

  // shared pointer compare unit, pointed at the owner or the current victim
  assign sel_ext = (state_q == ST_SCAN) ? IXW'(v_q) : IXW'(w_q);
  assign sel_idx = sel_ext[WW-1:0];
  assign sel_top = top_q[sel_idx];
  assign sel_bot = bot_q[sel_idx];
  assign fill    = sel_bot - sel_top;
  assign empty   = (fill == '0);
  assign full    = (fill >= FULL_FILL);
  assign nb      = sel_bot - PW'(1);
  assign hit     = !empty && (v_q != {1'b0, w_q});

  assign next_of_w = (({1'b0, w_q} + 3'd1) == live) ? 3'd0 : ({1'b0, w_q} + 3'd1);
  assign next_of_v = ((v_q + 3'd1) == live) ? 3'd0 : (v_q + 3'd1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (out_free) begin
          state_d = ST_IDLE;
          if (!w_bad) begin
            case (cmd_q)
              CMD_POP: begin
                if (!empty) state_d = ST_READ;
              end
              CMD_STEAL: begin
                if (live != 3'd1) state_d = ST_SCAN;
              end
              default: state_d = ST_IDLE;
            endcase
          end
        end
      end
      ST_SCAN: begin
        if (out_free) begin
          if (hit) begin
            state_d = ST_READ;
          end else if (tries_q == 3'd1) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_READ: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    top_d      = top_q;
    bot_d      = bot_q;
    v_d        = v_q;
    tries_d    = tries_q;
    fin        = 1'b0;
    fin_status = STATUS_EMPTY;
    fin_item   = '0;
    fin_src    = w_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = AW'({sel_idx, sel_bot[SW-1:0]});
    ram_raddr  = AW'({sel_idx, nb[SW-1:0]});
    case (state_q)
      ST_DECODE: begin
        if (out_free) begin
          if (w_bad) begin
            fin        = 1'b1;
            fin_status = STATUS_RANGE;
          end else begin
            case (cmd_q)
              CMD_PUSH: begin
                fin = 1'b1;
                if (full) begin
                  fin_status = STATUS_FULL;
                end else begin
                  ram_we           = 1'b1;
                  bot_d[sel_idx]   = sel_bot + PW'(1);
                  fin_status       = STATUS_OK;
                end
              end
              CMD_POP: begin
                if (empty) begin
                  fin = 1'b1;
                end else begin
                  ram_re = 1'b1;
                  v_d    = {1'b0, w_q};
                  if (nb == sel_top) begin
                    top_d[sel_idx] = sel_top + PW'(1);
                    bot_d[sel_idx] = sel_top + PW'(1);
                  end else begin
                    bot_d[sel_idx] = nb;
                  end
                end
              end
              CMD_STEAL: begin
                if (live == 3'd1) begin
                  fin = 1'b1;
                end else begin
                  v_d     = next_of_w;
                  tries_d = live - 3'd1;
                end
              end
              default: fin = 1'b1;
            endcase
          end
        end
      end
      ST_SCAN: begin
        ram_raddr = AW'({sel_idx, sel_top[SW-1:0]});
        if (out_free) begin
          if (hit) begin
            ram_re         = 1'b1;
            top_d[sel_idx] = sel_top + PW'(1);
          end else if (tries_q == 3'd1) begin
            fin = 1'b1;
          end else begin
            v_d     = next_of_v;
            tries_d = tries_q - 3'd1;
          end
        end
      end
      ST_READ: begin
        if (out_free) begin
          fin        = 1'b1;
          fin_status = STATUS_OK;
          fin_item   = ram_rdata;
          fin_src    = v_q[1:0];
        end
      end
      default: ;
    endcase
  end

  wsd_ram #(
    .WIDTH(ITEM_WIDTH),
    .DEPTH(RAM_DEPTH)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(item_q),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= ACTIVE_WORKERS_RESET;
      out_valid_q <= 1'b0;
      v_q         <= '0;
      tries_q     <= '0;
      for (int i = 0; i < NUM_WORKERS; i++) begin
        top_q[i] <= '0;
        bot_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      v_q     <= v_d;
      tries_q <= tries_d;
      top_q   <= top_d;
      bot_q   <= bot_d;
      if (cfg_valid_i) begin
        cfg_q <= cfg_active_workers_i;
      end
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q  <= cmd_i;
      w_q    <= worker_i;
      item_q <= work_item_i;
    end
    if (fin) begin
      status_q <= fin_status;
      taken_q  <= fin_item;
      src_q    <= fin_src;
    end
  end

  assign in_ready_o      = (state_q == ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign taken_item_o    = taken_q;
  assign source_worker_o = src_q;

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while a transaction was in flight");

  a_item_only_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STATUS_OK |-> taken_item_o == '0)
    else $error("nonzero item on a failed transaction");

  a_scan_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> tries_q != 3'd0 && v_q != {1'b0, w_q} && v_q < live)
    else $error("steal scan out of bounds");
`endif

endmodule

// ===== sim/tb_top.sv =====
// testbench for work_stealing_deque_set_core: queue-fed driver, clocked monitor, in-line
// deque predictor checked field by field; depends on wsd_pkg and the core rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wsd_pkg::*;

  localparam int NW = 4;
  localparam int DEPTH = 256;
  localparam int IW = 16;
  localparam int HOLD_CYCLES = 400;
  localparam int LIMIT_CYCLES = 400000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic [1:0]    cmd;
    logic [1:0]    worker;
    logic [IW-1:0] item;
  } job_t;

  typedef struct packed {
    logic [1:0]    status;
    logic [IW-1:0] taken;
    logic [1:0]    src;
  } outcome_t;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_ready_o;
  logic [1:0]    cmd_i;
  logic [1:0]    worker_i;
  logic [IW-1:0] work_item_i;
  logic          out_valid_o;
  logic          out_ready_i;
  logic [1:0]    status_o;
  logic [IW-1:0] taken_item_o;
  logic [1:0]    source_worker_o;
  logic          cfg_valid_i;
  logic          cfg_ready_o;
  logic [2:0]    cfg_active_workers_i;

  work_stealing_deque_set_core #(
    .NUM_WORKERS(NW),
    .DEQUE_DEPTH(DEPTH),
    .ITEM_WIDTH (IW)
  ) dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .cmd_i               (cmd_i),
    .worker_i            (worker_i),
    .work_item_i         (work_item_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .status_o            (status_o),
    .taken_item_o        (taken_item_o),
    .source_worker_o     (source_worker_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_active_workers_i(cfg_active_workers_i)
  );

  // predictor state
  logic [8:0]    top_ptr    [NW];
  logic [8:0]    bottom_ptr [NW];
  logic [IW-1:0] slot_mem   [NW][DEPTH];
  logic [2:0]    active_shadow;

  job_t       job_backlog[$];
  outcome_t   awaited_outcomes[$];
  idle_mode_e idle_mode;
  job_t       drv_job;
  outcome_t   want;
  outcome_t   got;
  bit         in_taken;
  bit         hold_go;
  int         hold_left;
  int         errors;
  int         jobs_in;
  int         results_seen;
  int         cfg_writes;
  int         status_count[4];
  int         watchdog_cycles;

  function automatic int clamp_workers(input logic [2:0] a);
    if (a == 3'd0) return 1;
    if (a > NW) return NW;
    return a;
  endfunction

  function automatic logic [8:0] fill_level(input int w);
    logic [8:0] d;
    d = bottom_ptr[w] - top_ptr[w];
    return d;
  endfunction

  function automatic outcome_t deque_apply(input logic [1:0] cmd, input logic [1:0] w,
                                           input logic [IW-1:0] item);
    outcome_t   r;
    int         n;
    int         v;
    bit         hit;
    logic [8:0] nb;
    logic [8:0] nt;
    n = clamp_workers(active_shadow);
    r.status = STATUS_EMPTY;
    r.taken = '0;
    r.src = w;
    if (w >= n) begin
      r.status = STATUS_RANGE;
    end else if (cmd == CMD_PUSH) begin
      if (fill_level(w) >= DEPTH - 1) begin
        r.status = STATUS_FULL;
      end else begin
        slot_mem[w][bottom_ptr[w][7:0]] = item;
        bottom_ptr[w] = bottom_ptr[w] + 9'd1;
        r.status = STATUS_OK;
      end
    end else if (cmd == CMD_POP) begin
      if (fill_level(w) != 0) begin
        nb = bottom_ptr[w] - 9'd1;
        r.taken = slot_mem[w][nb[7:0]];
        if (nb == top_ptr[w]) begin
          nt = top_ptr[w] + 9'd1;
          top_ptr[w] = nt;
          bottom_ptr[w] = nt;
        end else begin
          bottom_ptr[w] = nb;
        end
        r.status = STATUS_OK;
      end
    end else if (cmd == CMD_STEAL) begin
      hit = 0;
      for (int i = 0; i + 1 < n; i++) begin
        v = (w + 1 + i) % n;
        if (!hit && v != w && fill_level(v) != 0) begin
          r.taken = slot_mem[v][top_ptr[v][7:0]];
          top_ptr[v] = top_ptr[v] + 9'd1;
          r.src = 2'(v);
          r.status = STATUS_OK;
          hit = 1;
        end
      end
    end
    return r;
  endfunction

  function automatic bit stall_roll(input bit receiver_side);
    int pct;
    case (idle_mode)
      IDLE_SEND: pct = receiver_side ? 0 : 80;
      IDLE_RECV: pct = receiver_side ? 80 : 0;
      IDLE_BOTH: pct = 28;
      default:   pct = 0;
    endcase
    return $urandom_range(0, 99) < pct;
  endfunction

  task automatic add_job(input logic [1:0] cmd, input logic [1:0] w, input logic [IW-1:0] item);
    job_t j;
    j.cmd = cmd;
    j.worker = w;
    j.item = item;
    job_backlog.push_back(j);
  endtask

  task automatic add_burst(input logic [1:0] cmd, input logic [1:0] w, input int count);
    repeat (count) add_job(cmd, w, IW'($urandom));
  endtask

  task automatic add_random(input int count);
    int         roll;
    int         n;
    logic [1:0] cmd;
    logic [1:0] w;
    n = clamp_workers(active_shadow);
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) cmd = CMD_PUSH;
      else if (roll < 70) cmd = CMD_POP;
      else if (roll < 95) cmd = CMD_STEAL;
      else cmd = CMD_UNUSED;
      if ($urandom_range(0, 9) == 0) w = 2'($urandom_range(0, NW - 1));
      else w = 2'($urandom_range(0, n - 1));
      add_job(cmd, w, IW'($urandom));
    end
  endtask

  task automatic write_active(input logic [2:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_active_workers_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // sampled at the rising edge, where backlog and valid are settled
  task automatic wait_quiet();
    while (job_backlog.size() != 0 || in_valid_i || awaited_outcomes.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
  end
  always #10 clk_i = ~clk_i;

  // driver: one transaction at a time from the backlog
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (job_backlog.size() != 0 && !stall_roll(1'b0)) begin
        drv_job = job_backlog.pop_front();
        in_valid_i <= 1'b1;
        cmd_i <= drv_job.cmd;
        worker_i <= drv_job.worker;
        work_item_i <= drv_job.item;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver with long hold-off on request
  always @(negedge clk_i) begin
    if (hold_go) begin
      hold_left = HOLD_CYCLES;
      hold_go = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= rst_ni && !stall_roll(1'b1);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    in_taken = rst_ni && in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        active_shadow = cfg_active_workers_i;
        cfg_writes++;
      end
      if (in_taken) begin
        awaited_outcomes.push_back(deque_apply(cmd_i, worker_i, work_item_i));
        jobs_in++;
      end
      if (out_valid_o && out_ready_i) begin
        got.status = status_o;
        got.taken = taken_item_o;
        got.src = source_worker_o;
        if (awaited_outcomes.size() == 0) begin
          $display("%0t: result with nothing pending: status %0d item %h src %0d",
                   $time, got.status, got.taken, got.src);
          errors++;
        end else begin
          want = awaited_outcomes.pop_front();
          results_seen++;
          status_count[want.status]++;
          if (got.status != want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
          end
          if (got.taken != want.taken) begin
            $display("%0t: taken_item expected %h actual %h", $time, want.taken, got.taken);
            errors++;
          end
          if (got.src != want.src) begin
            $display("%0t: source_worker expected %0d actual %0d", $time, want.src, got.src);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    for (watchdog_cycles = 0; watchdog_cycles < LIMIT_CYCLES; watchdog_cycles++)
      @(posedge clk_i);
    $display("tb_top: timeout after %0d cycles", LIMIT_CYCLES);
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    cmd_i = '0;
    worker_i = '0;
    work_item_i = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_active_workers_i = ACTIVE_WORKERS_RESET;
    active_shadow = ACTIVE_WORKERS_RESET;
    idle_mode = IDLE_NONE;
    for (int w = 0; w < NW; w++) begin
      top_ptr[w] = '0;
      bottom_ptr[w] = '0;
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty cases, lifo order, steal scan order, unused cmd
    write_active(3'd4);
    add_job(CMD_POP, 2'd0, 16'h0000);
    add_job(CMD_STEAL, 2'd0, 16'h0000);
    add_job(CMD_PUSH, 2'd0, 16'h0000);
    add_job(CMD_PUSH, 2'd0, 16'hFFFF);
    add_job(CMD_PUSH, 2'd0, 16'h8001);
    add_job(CMD_POP, 2'd0, 16'h0000);
    add_job(CMD_STEAL, 2'd1, 16'hFFFF);
    add_job(CMD_POP, 2'd0, 16'h0000);
    add_job(CMD_POP, 2'd0, 16'h0000);
    add_job(CMD_PUSH, 2'd3, 16'h5A5A);
    add_job(CMD_STEAL, 2'd3, 16'h0000);
    add_job(CMD_STEAL, 2'd2, 16'h0000);
    add_job(CMD_UNUSED, 2'd0, 16'hABCD);
    add_job(CMD_PUSH, 2'd1, 16'h1234);
    add_job(CMD_STEAL, 2'd0, 16'h0000);
    add_job(CMD_PUSH, 2'd2, 16'hA5A5);
    add_job(CMD_UNUSED, 2'd2, 16'hFFFF);
    add_job(CMD_POP, 2'd2, 16'h0000);
    add_job(CMD_PUSH, 2'd3, 16'h7FFE);
    add_job(CMD_PUSH, 2'd3, 16'h0001);
    add_job(CMD_STEAL, 2'd1, 16'h0000);
    add_job(CMD_POP, 2'd3, 16'h0000);
    wait_quiet();

    // fill one deque past capacity, then steal from it
    add_random(60);
    add_burst(CMD_PUSH, 2'd1, 258);
    add_burst(CMD_STEAL, 2'd0, 130);
    wait_quiet();

    write_active(3'd1);
    idle_mode = IDLE_SEND;
    add_random(120);
    wait_quiet();

    write_active(3'd0);
    idle_mode = IDLE_RECV;
    add_random(80);
    wait_quiet();

    // second fill of the same deque wraps its pointers
    write_active(3'd2);
    idle_mode = IDLE_BOTH;
    add_burst(CMD_STEAL, 2'd0, 100);
    add_burst(CMD_PUSH, 2'd1, 258);
    add_burst(CMD_STEAL, 2'd0, 150);
    add_random(40);
    wait_quiet();

    write_active(3'd7);
    idle_mode = IDLE_NONE;
    add_random(150);
    hold_go = 1;
    wait_quiet();

    write_active(3'd3);
    idle_mode = IDLE_SEND;
    add_random(150);
    wait_quiet();

    write_active(3'd5);
    idle_mode = IDLE_RECV;
    add_random(100);
    wait_quiet();

    write_active(3'd6);
    idle_mode = IDLE_BOTH;
    add_random(100);
    wait_quiet();

    write_active(3'd4);
    idle_mode = IDLE_NONE;
    add_random(80);
    wait_quiet();

    repeat (20) @(posedge clk_i);
    if (awaited_outcomes.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, awaited_outcomes.size());
      errors++;
    end
    $display("tb_top: %0d transactions in, %0d results checked, %0d config writes",
             jobs_in, results_seen, cfg_writes);
    $display("tb_top: ok %0d, nothing available %0d, full %0d, out of range %0d",
             status_count[STATUS_OK], status_count[STATUS_EMPTY],
             status_count[STATUS_FULL], status_count[STATUS_RANGE]);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
